// File: hdl/vpu_pkg.sv
package vpu_pkg;

  localparam int CompW       = 16;
  localparam int SqrtBits    = 16;
  localparam int CordicSteps = 18;
  localparam int RemW        = 34;
  localparam int AccW        = 64;
  localparam int ProdW       = 48;
  localparam int CorW        = 33;
  localparam int AngW        = 26;
  localparam int TabW        = 21;
  localparam int CorShift    = 14;
  localparam int NormShift   = 28;

  localparam logic [15:0] Deg0   = 16'd0;
  localparam logic [15:0] Deg90  = 16'd11520;
  localparam logic [15:0] Deg180 = 16'd23040;
  localparam logic [15:0] Deg270 = 16'd34560;
  localparam logic [15:0] Deg360 = 16'd46080;

  typedef struct packed {
    logic                   xneg;
    logic                   yneg;
    logic                   xzero;
    logic                   yzero;
    logic [31:0]            s;
    logic [SqrtBits-1:0]    root;
    logic [RemW-1:0]        rrem;
    logic [SqrtBits-1:0]    tx;
    logic [SqrtBits-1:0]    ty;
    logic [AccW-1:0]        rx;
    logic [AccW-1:0]        ry;
    logic [ProdW-1:0]       qx;
    logic [ProdW-1:0]       qy;
    logic signed [CorW-1:0] cx;
    logic signed [CorW-1:0] cy;
    logic signed [AngW-1:0] cz;
  } vpu_work_t;

  function automatic logic [TabW-1:0] atan_step(input logic [4:0] i);
    logic [TabW-1:0] v;
    case (i)
      5'd0:    v = 21'd1474560;
      5'd1:    v = 21'd870484;
      5'd2:    v = 21'd459940;
      5'd3:    v = 21'd233473;
      5'd4:    v = 21'd117189;
      5'd5:    v = 21'd58652;
      5'd6:    v = 21'd29333;
      5'd7:    v = 21'd14667;
      5'd8:    v = 21'd7334;
      5'd9:    v = 21'd3667;
      5'd10:   v = 21'd1833;
      5'd11:   v = 21'd917;
      5'd12:   v = 21'd458;
      5'd13:   v = 21'd229;
      5'd14:   v = 21'd115;
      5'd15:   v = 21'd57;
      5'd16:   v = 21'd29;
      5'd17:   v = 21'd14;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/vpu_front.sv
module vpu_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [15:0]      vec_x,
  input  logic signed [15:0]      vec_y,
  output logic                    out_valid_r,
  output vpu_pkg::vpu_work_t      out_work_r
);

  logic        v1_r, v2_r;
  logic [15:0] ax1_r, ay1_r, ax2_r, ay2_r;
  logic [3:0]  flg1_r, flg2_r;
  logic [31:0] sqx2_r, sqy2_r;
  logic [15:0] ax_nxt, ay_nxt;
  logic [31:0] s_nxt;
  vpu_pkg::vpu_work_t work_nxt;

  always_comb begin
    ax_nxt = vec_x[15] ? 16'(-vec_x) : 16'(vec_x);
    ay_nxt = vec_y[15] ? 16'(-vec_y) : 16'(vec_y);
  end

  always_comb begin
    s_nxt            = sqx2_r + sqy2_r;
    work_nxt         = '0;
    work_nxt.xneg    = flg2_r[3];
    work_nxt.yneg    = flg2_r[2];
    work_nxt.xzero   = flg2_r[1];
    work_nxt.yzero   = flg2_r[0];
    work_nxt.s       = s_nxt;
    work_nxt.rrem    = vpu_pkg::RemW'(s_nxt);
    work_nxt.rx      = vpu_pkg::AccW'(sqx2_r) << vpu_pkg::NormShift;
    work_nxt.ry      = vpu_pkg::AccW'(sqy2_r) << vpu_pkg::NormShift;
    work_nxt.cx      = vpu_pkg::CorW'(ax2_r) << vpu_pkg::CorShift;
    work_nxt.cy      = vpu_pkg::CorW'(ay2_r) << vpu_pkg::CorShift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ax1_r      <= ax_nxt;
    ay1_r      <= ay_nxt;
    flg1_r     <= {vec_x[15], vec_y[15], vec_x == '0, vec_y == '0};
    sqx2_r     <= ax1_r * ax1_r;
    sqy2_r     <= ay1_r * ay1_r;
    ax2_r      <= ax1_r;
    ay2_r      <= ay1_r;
    flg2_r     <= flg1_r;
    out_work_r <= work_nxt;
  end

endmodule

// File: hdl/vpu_iter_stage.sv
module vpu_iter_stage #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  vpu_pkg::vpu_work_t   in_work,
  output logic                 out_valid_r,
  output vpu_pkg::vpu_work_t   out_work_r
);

  localparam bit DoDigit = STEP < vpu_pkg::SqrtBits;
  localparam int Bit     = DoDigit ? vpu_pkg::SqrtBits - 1 - STEP : 0;

  logic [vpu_pkg::TabW-1:0] atan_v;
  logic [vpu_pkg::RemW-1:0] trial_root;
  logic [vpu_pkg::AccW-1:0] trial_x, trial_y;
  logic signed [vpu_pkg::CorW-1:0] dx, dy;
  vpu_pkg::vpu_work_t work_nxt;

  always_comb begin
    atan_v     = vpu_pkg::atan_step(5'(STEP));
    dx         = in_work.cy >>> STEP;
    dy         = in_work.cx >>> STEP;
    trial_root = (vpu_pkg::RemW'(in_work.root) << (Bit + 1))
               + (vpu_pkg::RemW'(1) << (2 * Bit));
    trial_x    = (vpu_pkg::AccW'(in_work.qx) << (Bit + 1))
               + (vpu_pkg::AccW'(in_work.s) << (2 * Bit));
    trial_y    = (vpu_pkg::AccW'(in_work.qy) << (Bit + 1))
               + (vpu_pkg::AccW'(in_work.s) << (2 * Bit));
    work_nxt   = in_work;

    if (in_work.cy > 0) begin
      work_nxt.cx = in_work.cx + dx;
      work_nxt.cy = in_work.cy - dy;
      work_nxt.cz = in_work.cz + vpu_pkg::AngW'(atan_v);
    end else begin
      work_nxt.cx = in_work.cx - dx;
      work_nxt.cy = in_work.cy + dy;
      work_nxt.cz = in_work.cz - vpu_pkg::AngW'(atan_v);
    end

    if (DoDigit) begin
      if (in_work.rrem >= trial_root) begin
        work_nxt.rrem      = in_work.rrem - trial_root;
        work_nxt.root[Bit] = 1'b1;
      end
      if (trial_x <= in_work.rx) begin
        work_nxt.rx      = in_work.rx - trial_x;
        work_nxt.qx      = in_work.qx + (vpu_pkg::ProdW'(in_work.s) << Bit);
        work_nxt.tx[Bit] = 1'b1;
      end
      if (trial_y <= in_work.ry) begin
        work_nxt.ry      = in_work.ry - trial_y;
        work_nxt.qy      = in_work.qy + (vpu_pkg::ProdW'(in_work.s) << Bit);
        work_nxt.ty[Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_work_r <= work_nxt;
  end

endmodule

// File: hdl/vpu_back.sv
module vpu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  vpu_pkg::vpu_work_t   in_work,
  output logic                 out_valid_r,
  output logic [15:0]          out_magnitude_r,
  output logic [15:0]          out_angle_deg_r,
  output logic signed [15:0]   out_unit_x_r,
  output logic signed [15:0]   out_unit_y_r,
  output logic                 out_zero_vector_r
);

  logic signed [vpu_pkg::AngW-1:0] zr;
  logic [15:0] q, ang_nxt, mag_nxt, ux, uy;
  logic        zero;

  always_comb begin
    zero = in_work.xzero & in_work.yzero;
    zr   = (in_work.cz + vpu_pkg::AngW'(128)) >>> 8;
    if (zr < 0) begin
      q = '0;
    end else if (zr > $signed({1'b0, vpu_pkg::AngW'(vpu_pkg::Deg90)})) begin
      q = vpu_pkg::Deg90;
    end else begin
      q = zr[15:0];
    end

    if (in_work.xzero) begin
      ang_nxt = in_work.yneg ? vpu_pkg::Deg270 : vpu_pkg::Deg90;
    end else if (in_work.yzero) begin
      ang_nxt = in_work.xneg ? vpu_pkg::Deg180 : vpu_pkg::Deg0;
    end else if (!in_work.xneg && !in_work.yneg) begin
      ang_nxt = q;
    end else if (in_work.xneg && !in_work.yneg) begin
      ang_nxt = vpu_pkg::Deg180 - q;
    end else if (in_work.xneg) begin
      ang_nxt = vpu_pkg::Deg180 + q;
    end else if (q == '0) begin
      ang_nxt = vpu_pkg::Deg0;
    end else begin
      ang_nxt = vpu_pkg::Deg360 - q;
    end

    mag_nxt = in_work.root
            + 16'(in_work.rrem > vpu_pkg::RemW'(in_work.root));
    ux = in_work.tx + 16'((in_work.rx << 2)
       >= vpu_pkg::AccW'(in_work.s) + (vpu_pkg::AccW'(in_work.qx) << 2));
    uy = in_work.ty + 16'((in_work.ry << 2)
       >= vpu_pkg::AccW'(in_work.s) + (vpu_pkg::AccW'(in_work.qy) << 2));
    if (in_work.xneg) ux = 16'(-ux);
    if (in_work.yneg) uy = 16'(-uy);
    if (zero) begin
      ux = '0;
      uy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_magnitude_r   <= mag_nxt;
    out_angle_deg_r   <= ang_nxt;
    out_unit_x_r      <= ux;
    out_unit_y_r      <= uy;
    out_zero_vector_r <= zero;
  end

endmodule

// File: hdl/vector_polar_and_unit.sv
// Cartesian-to-polar converter with normalization, fully pipelined.
// Input: pulse start with in_vec_x / in_vec_y (signed Q8.8). busy is held
// low, so a beat is taken on every cycle that start is high.
// Output: out_valid is high for exactly one cycle per input beat, with
// out_magnitude (Q8.8, rounded), out_angle_deg (1/128 degree, 0..46079),
// out_unit_x / out_unit_y (Q1.14) and out_zero_vector.
// Pipeline: 3 front stages (abs, square, sum), 18 step stages that each run
// one CORDIC rotation, where steps 0 to 15 also produce one square-root digit
// and one digit of each unit component, and one output stage for rounding
// and quadrant mapping.
// Throughput: one beat per cycle; results leave in input order.
// The receiver cannot stall; every result appears once for one cycle.
// Reset: synchronous, active low; clears all valid bits, so beats in flight
// are dropped and out_valid stays low until new beats arrive.
// The zero vector gives magnitude 0, angle 90 degrees, a zero unit vector
// and out_zero_vector high.
module vector_polar_and_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_vec_x,
  input  logic signed [15:0] in_vec_y,
  output logic               out_valid,
  output logic [15:0]        out_magnitude,
  output logic [15:0]        out_angle_deg,
  output logic signed [15:0] out_unit_x,
  output logic signed [15:0] out_unit_y,
  output logic               out_zero_vector
);

  localparam int Steps = vpu_pkg::CordicSteps;

  logic               vld [Steps+1];
  vpu_pkg::vpu_work_t wrk [Steps+1];

  assign busy = 1'b0;

  vpu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start),
    .vec_x       (in_vec_x),
    .vec_y       (in_vec_y),
    .out_valid_r (vld[0]),
    .out_work_r  (wrk[0])
  );

  for (genvar i = 0; i < Steps; i++) begin : g_step
    vpu_iter_stage #(.STEP(i)) u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .in_valid    (vld[i]),
      .in_work     (wrk[i]),
      .out_valid_r (vld[i+1]),
      .out_work_r  (wrk[i+1])
    );
  end

  vpu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (vld[Steps]),
    .in_work           (wrk[Steps]),
    .out_valid_r       (out_valid),
    .out_magnitude_r   (out_magnitude),
    .out_angle_deg_r   (out_angle_deg),
    .out_unit_x_r      (out_unit_x),
    .out_unit_y_r      (out_unit_y),
    .out_zero_vector_r (out_zero_vector)
  );

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_vector |-> out_magnitude == '0 && out_unit_x == '0
      && out_unit_y == '0 && out_angle_deg == vpu_pkg::Deg90)
    else $error("zero vector result malformed");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_deg < vpu_pkg::Deg360)
    else $error("angle out of range");

  a_nonzero_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_vector |-> out_magnitude != '0)
    else $error("nonzero vector with zero magnitude");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

// File: verif/vpu_checker.sv
`timescale 1ns / 1ps
module vpu_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_vec_x,
  input  logic signed [15:0] in_vec_y,
  input  logic               out_valid,
  input  logic [15:0]        out_magnitude,
  input  logic [15:0]        out_angle_deg,
  input  logic signed [15:0] out_unit_x,
  input  logic signed [15:0] out_unit_y,
  input  logic               out_zero_vector,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic [15:0] magnitude;
    logic [15:0] angle_deg;
    logic [15:0] unit_x;
    logic [15:0] unit_y;
    logic        zero_vector;
  } polar_t;

  polar_t polar_q[$];

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_units(int i);
    longint tab[18] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
                        7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14};
    return tab[i];
  endfunction

  function automatic longint first_quad_angle(longint ax, longint ay);
    longint cx, cy, cz, dx, dy, q;
    cx = ax * 16384;
    cy = ay * 16384;
    cz = 0;
    for (int i = 0; i < 18; i++) begin
      dx = shr_floor(cy, i);
      dy = shr_floor(cx, i);
      if (cy > 0) begin
        cx += dx; cy -= dy; cz += atan_units(i);
      end else begin
        cx -= dx; cy += dy; cz -= atan_units(i);
      end
    end
    q = shr_floor(cz + 128, 8);
    if (q < 0) q = 0;
    if (q > 11520) q = 11520;
    return q;
  endfunction

  function automatic longint unit_component(longint a, longint s);
    longint n, t, c;
    n = (a * a) << 28;
    t = 0;
    for (int b = 15; b >= 0; b--) begin
      c = t | (longint'(1) << b);
      if (c * c * s <= n) t = c;
    end
    if ((2 * t + 1) * (2 * t + 1) * s <= 4 * n) t++;
    return t;
  endfunction

  function automatic polar_t to_polar(logic signed [15:0] vx, logic signed [15:0] vy);
    polar_t r;
    longint x, y, ax, ay, s, m, c, ang, q, ux, uy;
    x = vx;
    y = vy;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    s = ax * ax + ay * ay;
    if (s == 0) begin
      r.magnitude = 0; r.angle_deg = vpu_pkg::Deg90; r.unit_x = 0; r.unit_y = 0;
      r.zero_vector = 1;
      return r;
    end
    m = 0;
    for (int b = 15; b >= 0; b--) begin
      c = m | (longint'(1) << b);
      if (c * c <= s) m = c;
    end
    if (s - m * m > m) m++;
    if (x == 0) ang = y >= 0 ? vpu_pkg::Deg90 : vpu_pkg::Deg270;
    else if (y == 0) ang = x > 0 ? vpu_pkg::Deg0 : vpu_pkg::Deg180;
    else begin
      q = first_quad_angle(ax, ay);
      if (x > 0 && y > 0) ang = q;
      else if (x < 0 && y > 0) ang = vpu_pkg::Deg180 - q;
      else if (x < 0) ang = vpu_pkg::Deg180 + q;
      else ang = vpu_pkg::Deg360 - q;
      if (ang >= vpu_pkg::Deg360) ang -= vpu_pkg::Deg360;
    end
    ux = unit_component(ax, s);
    uy = unit_component(ay, s);
    if (x < 0) ux = -ux;
    if (y < 0) uy = -uy;
    r.magnitude = m[15:0];
    r.angle_deg = ang[15:0];
    r.unit_x = ux[15:0];
    r.unit_y = uy[15:0];
    r.zero_vector = 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    polar_t e;
    if (rst_n) begin
      if (start && !busy) polar_q.push_back(to_polar(in_vec_x, in_vec_y));
      if (out_valid) begin
        if (polar_q.size() == 0) begin
          $display("unexpected result beat at %0t", $time);
          fail_count++;
        end else begin
          e = polar_q.pop_front();
          if (out_magnitude !== e.magnitude)
            report_mismatch("magnitude", out_magnitude, e.magnitude);
          if (out_angle_deg !== e.angle_deg)
            report_mismatch("angle_deg", out_angle_deg, e.angle_deg);
          if (out_unit_x !== e.unit_x) report_mismatch("unit_x", out_unit_x, e.unit_x);
          if (out_unit_y !== e.unit_y) report_mismatch("unit_y", out_unit_y, e.unit_y);
          if (out_zero_vector !== e.zero_vector)
            report_mismatch("zero_vector", out_zero_vector, e.zero_vector);
        end
      end
      pending = polar_q.size();
    end
  end
endmodule

// File: verif/tb_vector_polar_and_unit.sv
`timescale 1ns / 1ps
module tb_vector_polar_and_unit;
  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic signed [15:0] in_vec_x = 0;
  logic signed [15:0] in_vec_y = 0;
  logic               out_valid;
  logic [15:0]        out_magnitude;
  logic [15:0]        out_angle_deg;
  logic signed [15:0] out_unit_x;
  logic signed [15:0] out_unit_y;
  logic               out_zero_vector;
  int                 fail_count;
  int                 pending;

  always #5 clk = ~clk;

  vector_polar_and_unit u_top (.*);

  vpu_checker u_checker (.*);

  task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y);
    start <= 1;
    in_vec_x <= x;
    in_vec_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] random_component();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return 16'($signed($urandom_range(0, 8)) - 4);
      2: return '0;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic signed [15:0] edge_vals[8] = '{0, 1, -1, 256, -256, 16'sh7fff, 16'sh8000, 100};
    int left, burst;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 8; i += 1)
      for (int j = 0; j < 3; j += 1) send_vector(edge_vals[i], edge_vals[(i + j * 3) % 8]);
    send_vector(16'sh8000, 16'sh8000);
    start <= 0;
    while (pending != 0) @(posedge clk);
    left = 600;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && left > 0; k++) begin
        send_vector(random_component(), random_component());
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("PASS vector_polar_and_unit");
    else $display("FAIL vector_polar_and_unit");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL vector_polar_and_unit");
    $finish;
  end
endmodule
